/* hw/rtl/odr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odr_pkg: shared constants and helpers for the odometry dead-reckoning core
// Fixed-point constants (Q16.16 angles, Q2.30 trig), arctangent table and
// saturation helper used by the core and its CORDIC unit.
// ----------------------------------------------------------------------------
package odr_pkg;

   // default number of CORDIC micro-rotations
   localparam int CORDIC_STEPS_DEF = 16;

   // arctangent table index width (table lists 17 entries, zero beyond)
   localparam int ATAN_IDX_W = 5;

   // wrapped heading width, signed Q16.16 within minus pi to pi
   localparam int HEAD_W = 19;

   // angle constants in Q16.16
   localparam int PI_Q      = 205887;
   localparam int TWO_PI_Q  = 411775;
   localparam int HALF_PI_Q = 102944;

   // CORDIC gain reciprocal and unity, both Q2.30
   localparam int CORDIC_K = 652032874;
   localparam int ONE_Q30  = 1073741824;

   // CORDIC datapath widths
   localparam int CXY_W = 34;
   localparam int CZ_W  = 24;

   // heading wrap reduction: remainder width, bias and top shift
   localparam int REM_W        = 36;
   localparam int WRAP_BIAS_SH = 15;
   localparam int WRAP_TOP     = 16;
   localparam logic [REM_W-1:0] WRAP_BIAS = REM_W'(TWO_PI_Q) << WRAP_BIAS_SH;

   // arctangent of 2^-i in Q16.16, rounded
   function automatic logic [16:0] atan_lookup(input logic [ATAN_IDX_W-1:0] idx);
      logic [16:0] val;
      case (idx)
         5'd0:    val = 17'd51472;
         5'd1:    val = 17'd30386;
         5'd2:    val = 17'd16055;
         5'd3:    val = 17'd8150;
         5'd4:    val = 17'd4091;
         5'd5:    val = 17'd2047;
         5'd6:    val = 17'd1024;
         5'd7:    val = 17'd512;
         5'd8:    val = 17'd256;
         5'd9:    val = 17'd128;
         5'd10:   val = 17'd64;
         5'd11:   val = 17'd32;
         5'd12:   val = 17'd16;
         5'd13:   val = 17'd8;
         5'd14:   val = 17'd4;
         5'd15:   val = 17'd2;
         5'd16:   val = 17'd1;
         default: val = 17'd0;
      endcase
      return val;
   endfunction

   // saturate a 36-bit signed value to the 32-bit signed range
   function automatic logic signed [31:0] sat32(input logic signed [35:0] v);
      logic signed [31:0] res;
      if (v > 36'sh0_7FFF_FFFF) begin
         res = 32'sh7FFF_FFFF;
      end else if (v < -36'sh0_8000_0000) begin
         res = 32'sh8000_0000;
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

endpackage

/* hw/rtl/odr_cordic.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odr_cordic: iterative rotation-mode CORDIC sine and cosine
// Folds the angle into minus pi/2 to pi/2, runs one micro-rotation per cycle
// on a shared shift-add datapath, then negates if folded and clamps to Q2.30.
// ----------------------------------------------------------------------------
module odr_cordic #(
   parameter int CORDIC_STEPS = odr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [odr_pkg::HEAD_W-1:0] angle,
   output logic                              done,
   output logic signed [31:0]                cos_out,
   output logic signed [31:0]                sin_out
);

   typedef enum logic [2:0] {
      CS_IDLE = 3'b001,
      CS_RUN  = 3'b010,
      CS_FIX  = 3'b100
   } cstate_type;

   localparam logic [odr_pkg::ATAN_IDX_W-1:0] LAST_IDX =
      odr_pkg::ATAN_IDX_W'(CORDIC_STEPS - 1);

   cstate_type                          state_ff, state_in;
   logic [odr_pkg::ATAN_IDX_W-1:0]      idx_ff, idx_in;
   logic signed [odr_pkg::CXY_W-1:0]    x_ff, x_in;
   logic signed [odr_pkg::CXY_W-1:0]    y_ff, y_in;
   logic signed [odr_pkg::CZ_W-1:0]     z_ff, z_in;
   logic                                neg_ff, neg_in;
   logic                                done_ff, done_in;
   logic signed [31:0]                  cos_ff, cos_in;
   logic signed [31:0]                  sin_ff, sin_in;

   logic signed [odr_pkg::CZ_W-1:0]     ang_ext;
   logic signed [odr_pkg::CXY_W-1:0]    xs, ys, xf, yf;
   logic signed [odr_pkg::CZ_W-1:0]     atan_ext;

   // fixed-point clamp to plus or minus one in Q2.30
   function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
      logic signed [31:0] res;
      if (v > 34'(odr_pkg::ONE_Q30)) begin
         res = 32'(odr_pkg::ONE_Q30);
      end else if (v < -34'(odr_pkg::ONE_Q30)) begin
         res = -32'(odr_pkg::ONE_Q30);
      end else begin
         res = v[31:0];
      end
      return res;
   endfunction

   assign ang_ext  = {{(odr_pkg::CZ_W - odr_pkg::HEAD_W){angle[odr_pkg::HEAD_W-1]}}, angle};
   assign atan_ext = {7'd0, odr_pkg::atan_lookup(idx_ff)};
   assign xs       = x_ff >>> idx_ff;
   assign ys       = y_ff >>> idx_ff;
   assign xf       = neg_ff ? -x_ff : x_ff;
   assign yf       = neg_ff ? -y_ff : y_ff;

   // sequencer and shift-add datapath
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      x_in     = x_ff;
      y_in     = y_ff;
      z_in     = z_ff;
      neg_in   = neg_ff;
      done_in  = 1'b0;
      cos_in   = cos_ff;
      sin_in   = sin_ff;
      case (state_ff)
         CS_IDLE: begin
            if (start) begin
               // fold into the right half plane
               x_in   = odr_pkg::CXY_W'(odr_pkg::CORDIC_K);
               y_in   = '0;
               idx_in = '0;
               if (ang_ext > odr_pkg::CZ_W'(odr_pkg::HALF_PI_Q)) begin
                  z_in   = ang_ext - odr_pkg::CZ_W'(odr_pkg::PI_Q);
                  neg_in = 1'b1;
               end else if (ang_ext < -odr_pkg::CZ_W'(odr_pkg::HALF_PI_Q)) begin
                  z_in   = ang_ext + odr_pkg::CZ_W'(odr_pkg::PI_Q);
                  neg_in = 1'b1;
               end else begin
                  z_in   = ang_ext;
                  neg_in = 1'b0;
               end
               state_in = CS_RUN;
            end
         end
         CS_RUN: begin
            // one micro-rotation per cycle
            if (!z_ff[odr_pkg::CZ_W-1]) begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_ext;
            end else begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_ext;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = CS_FIX;
            end
         end
         CS_FIX: begin
            // undo the fold and clamp
            cos_in   = clamp_q30(xf);
            sin_in   = clamp_q30(yf);
            done_in  = 1'b1;
            state_in = CS_IDLE;
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      z_ff   <= z_in;
      neg_ff <= neg_in;
      cos_ff <= cos_in;
      sin_ff <= sin_in;
   end

   assign done    = done_ff;
   assign cos_out = cos_ff;
   assign sin_out = sin_ff;

endmodule

/* hw/rtl/odometry_dead_reckoning_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// odometry_dead_reckoning_core: differential-drive odometry integrator
// Integrates base readings (cumulative distance and bearing) into a wrapped
// heading and a saturating x/y position, and rotates the speed into x and y.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries one base reading per transaction (distance, bearing,
//   translational and rotational speed, all signed Q16.16). rsp channel
//   carries position, wrapped heading, velocity in x and y and the yaw rate.
//   Both channels use valid/stall; a transaction completes on valid && !stall.
// Sequencing:
//   The first reading after reset only records distance and bearing and
//   gives no response. Every later reading gives one response, and no new
//   reading is taken until the previous one is finished. The time is set
//   by the 17-step heading wrap reduction, the one-rotation-per-cycle
//   CORDIC and the single multiplier shared by four products; req_stall is
//   high for that whole time.
// Reset and stall:
//   Synchronous reset clears heading, position and the first-reading flag.
//   The response sits in an output register; while rsp_stall is high it holds
//   and a new reading can still be accepted and worked on, and only the final
//   load waits for the output register to free up.
// ----------------------------------------------------------------------------
module odometry_dead_reckoning_core #(
   parameter int CORDIC_STEPS = odr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [31:0]                req_distance_total,
   input  logic signed [31:0]                req_bearing_total,
   input  logic signed [31:0]                req_trans_speed,
   input  logic signed [31:0]                req_rot_speed,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [31:0]                rsp_pos_x,
   output logic signed [31:0]                rsp_pos_y,
   output logic signed [odr_pkg::HEAD_W-1:0] rsp_heading_out,
   output logic signed [31:0]                rsp_vel_x,
   output logic signed [31:0]                rsp_vel_y,
   output logic signed [31:0]                rsp_yaw_rate
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_WRAP = 5'b00010,
      ST_TRIG = 5'b00100,
      ST_MUL  = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

   localparam int HW = odr_pkg::HEAD_W;
   localparam int RW = odr_pkg::REM_W;

   // control state
   state_type                state_ff, state_in;
   logic                     seen_first_ff, seen_first_in;
   logic [4:0]               step_ff, step_in;
   logic [2:0]               mstep_ff, mstep_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   // working state
   logic signed [31:0]       prev_distance_ff, prev_distance_in;
   logic signed [31:0]       prev_bearing_ff, prev_bearing_in;
   logic signed [HW-1:0]     heading_ff, heading_in;
   logic signed [31:0]       x_acc_ff, x_acc_in;
   logic signed [31:0]       y_acc_ff, y_acc_in;
   logic signed [32:0]       dd_ff, dd_in;
   logic signed [31:0]       tv_ff, tv_in;
   logic signed [31:0]       rv_ff, rv_in;
   logic [RW-1:0]            rem_ff, rem_in;
   logic signed [64:0]       prod_ff, prod_in;
   logic signed [31:0]       vx_ff, vx_in;
   logic signed [31:0]       vy_ff, vy_in;

   // response registers
   logic signed [31:0]       rsp_pos_x_ff, rsp_pos_x_in;
   logic signed [31:0]       rsp_pos_y_ff, rsp_pos_y_in;
   logic signed [HW-1:0]     rsp_heading_ff, rsp_heading_in;
   logic signed [31:0]       rsp_vel_x_ff, rsp_vel_x_in;
   logic signed [31:0]       rsp_vel_y_ff, rsp_vel_y_in;
   logic signed [31:0]       rsp_yaw_ff, rsp_yaw_in;

   // datapath wires
   logic                     req_take;
   logic                     out_free;
   logic [RW-1:0]            wrap_div;
   logic [RW:0]              wrap_sub;
   logic [RW-1:0]            rem_step;
   logic [HW:0]              head_calc;
   logic                     trig_start;
   logic                     trig_done;
   logic signed [31:0]       trig_cos, trig_sin;
   logic signed [32:0]       mul_a;
   logic signed [31:0]       mul_b;
   logic signed [64:0]       prod_rnd;
   logic signed [34:0]       rnd_q;
   logic signed [31:0]       acc_sel;
   logic signed [35:0]       acc_sum;
   logic signed [31:0]       acc_sat;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // heading wrap: one conditional subtract of 2*pi << k per cycle
   assign wrap_div  = RW'(odr_pkg::TWO_PI_Q) << step_ff;
   assign wrap_sub  = {1'b0, rem_ff} - {1'b0, wrap_div};
   assign rem_step  = wrap_sub[RW] ? rem_ff : wrap_sub[RW-1:0];
   assign head_calc = {1'b0, rem_step[HW-1:0]} - (HW+1)'(odr_pkg::PI_Q);

   // shared multiplier: dd*cos, dd*sin, tv*cos, tv*sin
   assign mul_a    = mstep_ff[2] ? {tv_ff[31], tv_ff} : dd_ff;
   assign mul_b    = mstep_ff[1] ? trig_sin : trig_cos;
   assign prod_in  = mul_a * mul_b;

   // round Q30 product, add accumulator, saturate
   assign prod_rnd = prod_ff + 65'sd536870912;
   assign rnd_q    = prod_rnd[64:30];
   assign acc_sel  = mstep_ff[2] ? 32'sd0 : (mstep_ff[1] ? y_acc_ff : x_acc_ff);
   assign acc_sum  = {{4{acc_sel[31]}}, acc_sel} + {rnd_q[34], rnd_q};
   assign acc_sat  = odr_pkg::sat32(acc_sum);

   assign trig_start = (state_ff == ST_WRAP) && (step_ff == 5'd0);

   odr_cordic #(
      .CORDIC_STEPS (CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (trig_start),
      .angle   (heading_in),
      .done    (trig_done),
      .cos_out (trig_cos),
      .sin_out (trig_sin)
   );

   // sequencer
   always_comb begin
      state_in         = state_ff;
      seen_first_in    = seen_first_ff;
      step_in          = step_ff;
      mstep_in         = mstep_ff;
      prev_distance_in = prev_distance_ff;
      prev_bearing_in  = prev_bearing_ff;
      heading_in       = heading_ff;
      x_acc_in         = x_acc_ff;
      y_acc_in         = y_acc_ff;
      dd_in            = dd_ff;
      tv_in            = tv_ff;
      rv_in            = rv_ff;
      rem_in           = rem_ff;
      vx_in            = vx_ff;
      vy_in            = vy_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;
      rsp_pos_x_in     = rsp_pos_x_ff;
      rsp_pos_y_in     = rsp_pos_y_ff;
      rsp_heading_in   = rsp_heading_ff;
      rsp_vel_x_in     = rsp_vel_x_ff;
      rsp_vel_y_in     = rsp_vel_y_ff;
      rsp_yaw_in       = rsp_yaw_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               prev_distance_in = req_distance_total;
               prev_bearing_in  = req_bearing_total;
               if (!seen_first_ff) begin
                  // first reading only records the counters
                  seen_first_in = 1'b1;
               end else begin
                  dd_in  = {req_distance_total[31], req_distance_total}
                         - {prev_distance_ff[31], prev_distance_ff};
                  tv_in  = req_trans_speed;
                  rv_in  = req_rot_speed;
                  // biased so the remainder search starts non-negative
                  rem_in = RW'($unsigned({{(RW-HW){heading_ff[HW-1]}}, heading_ff}))
                         + {{(RW-32){req_bearing_total[31]}}, req_bearing_total}
                         - {{(RW-32){prev_bearing_ff[31]}}, prev_bearing_ff}
                         + RW'(odr_pkg::PI_Q)
                         + odr_pkg::WRAP_BIAS;
                  step_in  = 5'(odr_pkg::WRAP_TOP);
                  state_in = ST_WRAP;
               end
            end
         end
         ST_WRAP: begin
            rem_in  = rem_step;
            step_in = step_ff - 1'b1;
            if (step_ff == 5'd0) begin
               heading_in = head_calc[HW-1:0];
               state_in   = ST_TRIG;
            end
         end
         ST_TRIG: begin
            if (trig_done) begin
               mstep_in = 3'd0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            // even cycles multiply, odd cycles round and accumulate
            if (mstep_ff[0]) begin
               case (mstep_ff[2:1])
                  2'd0:    x_acc_in = acc_sat;
                  2'd1:    y_acc_in = acc_sat;
                  2'd2:    vx_in    = acc_sat;
                  default: vy_in    = acc_sat;
               endcase
            end
            mstep_in = mstep_ff + 1'b1;
            if (mstep_ff == 3'd7) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               rsp_pos_x_in   = x_acc_ff;
               rsp_pos_y_in   = y_acc_ff;
               rsp_heading_in = heading_ff;
               rsp_vel_x_in   = vx_ff;
               rsp_vel_y_in   = vy_ff;
               rsp_yaw_in     = rv_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control and integrator state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         seen_first_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         prev_distance_ff <= '0;
         prev_bearing_ff  <= '0;
         heading_ff       <= '0;
         x_acc_ff         <= '0;
         y_acc_ff         <= '0;
      end else begin
         state_ff         <= state_in;
         seen_first_ff    <= seen_first_in;
         rsp_valid_ff     <= rsp_valid_in;
         prev_distance_ff <= prev_distance_in;
         prev_bearing_ff  <= prev_bearing_in;
         heading_ff       <= heading_in;
         x_acc_ff         <= x_acc_in;
         y_acc_ff         <= y_acc_in;
      end
   end

   // working and response payload
   always_ff @(posedge clock) begin
      step_ff        <= step_in;
      mstep_ff       <= mstep_in;
      dd_ff          <= dd_in;
      tv_ff          <= tv_in;
      rv_ff          <= rv_in;
      rem_ff         <= rem_in;
      prod_ff        <= prod_in;
      vx_ff          <= vx_in;
      vy_ff          <= vy_in;
      rsp_pos_x_ff   <= rsp_pos_x_in;
      rsp_pos_y_ff   <= rsp_pos_y_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_vel_x_ff   <= rsp_vel_x_in;
      rsp_vel_y_ff   <= rsp_vel_y_in;
      rsp_yaw_ff     <= rsp_yaw_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pos_x       = rsp_pos_x_ff;
   assign rsp_pos_y       = rsp_pos_y_ff;
   assign rsp_heading_out = rsp_heading_ff;
   assign rsp_vel_x       = rsp_vel_x_ff;
   assign rsp_vel_y       = rsp_vel_y_ff;
   assign rsp_yaw_rate    = rsp_yaw_ff;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for odometry_dead_reckoning_core
// Feeds base readings (directed corners, then a random walk mixed with noise
// and field extremes), integrates the same readings in a fixed-point pose
// tracker and checks every response field by field, in order.
// ----------------------------------------------------------------------------

typedef struct {
   logic signed [31:0] distance_total;
   logic signed [31:0] bearing_total;
   logic signed [31:0] trans_speed;
   logic signed [31:0] rot_speed;
} reading_type;

typedef struct {
   logic signed [31:0]                pos_x;
   logic signed [31:0]                pos_y;
   logic signed [odr_pkg::HEAD_W-1:0] heading_out;
   logic signed [31:0]                vel_x;
   logic signed [31:0]                vel_y;
   logic signed [31:0]                yaw_rate;
} pose_type;

localparam int TRIG_STEPS = 16;

// integrates readings into poses and holds the poses still owed by the core
class pose_tracker_type;
   bit                 primed;
   logic signed [31:0] last_dist;
   logic signed [31:0] last_bear;
   logic signed [31:0] heading_q;
   logic signed [31:0] x_q;
   logic signed [31:0] y_q;
   longint             atan_q16 [24];
   pose_type           pending_poses [$];
   int                 mismatches;

   function new();
      atan_q16 = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                   256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0, 0, 0, 0, 0};
      primed     = 1'b0;
      last_dist  = '0;
      last_bear  = '0;
      heading_q  = '0;
      x_q        = '0;
      y_q        = '0;
      mismatches = 0;
   endfunction

   function longint clip32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   function longint clamp_unit(longint v);
      if (v > odr_pkg::ONE_Q30) return odr_pkg::ONE_Q30;
      if (v < -odr_pkg::ONE_Q30) return -odr_pkg::ONE_Q30;
      return v;
   endfunction

   // q16.16 times q2.30, rounded half up
   function longint scale_q30(longint a, longint q30);
      return (a * q30 + (longint'(1) << 29)) >>> 30;
   endfunction

   // rotation-mode cordic, results in q2.30
   function void heading_trig(input longint ang, output longint c, output longint s);
      longint x;
      longint y;
      longint z;
      longint xs;
      longint ys;
      bit     flip;
      x    = odr_pkg::CORDIC_K;
      y    = 0;
      z    = ang;
      flip = 1'b0;
      // fold into the right half plane, undone by negating both outputs
      if (z > odr_pkg::HALF_PI_Q) begin
         z    = z - odr_pkg::PI_Q;
         flip = 1'b1;
      end else if (z < -odr_pkg::HALF_PI_Q) begin
         z    = z + odr_pkg::PI_Q;
         flip = 1'b1;
      end
      for (int i = 0; i < TRIG_STEPS && i < 24; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x = x - ys;
            y = y + xs;
            z = z - atan_q16[i];
         end else begin
            x = x + ys;
            y = y - xs;
            z = z + atan_q16[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = clamp_unit(x);
      s = clamp_unit(y);
   endfunction

   function void take_reading(reading_type rd);
      longint   h;
      longint   r;
      longint   c;
      longint   s;
      longint   dd;
      longint   nx;
      longint   ny;
      pose_type p;
      // first reading after reset only latches the counters
      if (!primed) begin
         primed    = 1'b1;
         last_dist = rd.distance_total;
         last_bear = rd.bearing_total;
         return;
      end
      // heading wrap into minus pi to pi
      h = longint'(heading_q) + (longint'(rd.bearing_total) - longint'(last_bear))
          + odr_pkg::PI_Q;
      r = h % odr_pkg::TWO_PI_Q;
      if (r < 0) r = r + odr_pkg::TWO_PI_Q;
      h = r - odr_pkg::PI_Q;
      heading_trig(h, c, s);
      // position update with saturation
      dd = longint'(rd.distance_total) - longint'(last_dist);
      nx = clip32(longint'(x_q) + scale_q30(dd, c));
      ny = clip32(longint'(y_q) + scale_q30(dd, s));
      heading_q = 32'(h);
      x_q       = 32'(nx);
      y_q       = 32'(ny);
      last_dist = rd.distance_total;
      last_bear = rd.bearing_total;
      p.pos_x       = 32'(nx);
      p.pos_y       = 32'(ny);
      p.heading_out = h[odr_pkg::HEAD_W-1:0];
      p.vel_x       = 32'(clip32(scale_q30(longint'(rd.trans_speed), c)));
      p.vel_y       = 32'(clip32(scale_q30(longint'(rd.trans_speed), s)));
      p.yaw_rate    = rd.rot_speed;
      pending_poses.push_back(p);
   endfunction

   function void compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   function void check_pose(pose_type got);
      pose_type want;
      if (pending_poses.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: pos_x %0d pos_y %0d heading %0d",
                     got.pos_x, got.pos_y, got.heading_out);
         return;
      end
      want = pending_poses.pop_front();
      compare_field("pos_x", want.pos_x, got.pos_x);
      compare_field("pos_y", want.pos_y, got.pos_y);
      compare_field("heading_out", 32'(want.heading_out), 32'(got.heading_out));
      compare_field("vel_x", want.vel_x, got.vel_x);
      compare_field("vel_y", want.vel_y, got.vel_y);
      compare_field("yaw_rate", want.yaw_rate, got.yaw_rate);
   endfunction

   function int outstanding();
      return pending_poses.size();
   endfunction
endclass

module tb_top;

   localparam int RANDOM_ITEMS = 640;
   localparam int QUIET_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 60;

   logic                              clock              = 1'b0;
   logic                              reset              = 1'b1;
   logic                              req_valid          = 1'b0;
   logic                              req_stall;
   logic signed [31:0]                req_distance_total = '0;
   logic signed [31:0]                req_bearing_total  = '0;
   logic signed [31:0]                req_trans_speed    = '0;
   logic signed [31:0]                req_rot_speed      = '0;
   logic                              rsp_valid;
   logic                              rsp_stall          = 1'b0;
   logic signed [31:0]                rsp_pos_x;
   logic signed [31:0]                rsp_pos_y;
   logic signed [odr_pkg::HEAD_W-1:0] rsp_heading_out;
   logic signed [31:0]                rsp_vel_x;
   logic signed [31:0]                rsp_vel_y;
   logic signed [31:0]                rsp_yaw_rate;

   pose_tracker_type   poses;
   pose_type           rsp_seen;
   int                 idle_odds    = 0;
   int                 stall_left   = 0;
   int                 quiet_cycles = 0;
   logic signed [31:0] cur_dist;
   logic signed [31:0] cur_bear;

   odometry_dead_reckoning_core #(
      .CORDIC_STEPS(TRIG_STEPS)
   ) u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_distance_total (req_distance_total),
      .req_bearing_total  (req_bearing_total),
      .req_trans_speed    (req_trans_speed),
      .req_rot_speed      (req_rot_speed),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_heading_out    (rsp_heading_out),
      .rsp_vel_x          (rsp_vel_x),
      .rsp_vel_y          (rsp_vel_y),
      .rsp_yaw_rate       (rsp_yaw_rate)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // one reading per transaction, optional idle burst ahead of it
   task automatic send_reading(input logic [31:0] dist_word, input logic [31:0] bear,
                               input logic [31:0] tv, input logic [31:0] rv);
      reading_type rd;
      rd.distance_total = dist_word;
      rd.bearing_total  = bear;
      rd.trans_speed    = tv;
      rd.rot_speed      = rv;
      if (idle_odds != 0 && $urandom_range(1, 100) <= idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_distance_total <= dist_word;
      req_bearing_total  <= bear;
      req_trans_speed    <= tv;
      req_rot_speed      <= rv;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      poses.take_reading(rd);
   endtask

   // field extremes and angle landmarks
   function automatic logic [31:0] corner_word();
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0:       v = 32'h8000_0000;
         1:       v = 32'h7FFF_FFFF;
         2:       v = 32'h0000_0000;
         3:       v = 32'hFFFF_FFFF;
         4:       v = 32'h0000_0001;
         5:       v = odr_pkg::PI_Q;
         6:       v = -odr_pkg::PI_Q;
         7:       v = odr_pkg::HALF_PI_Q;
         8:       v = odr_pkg::TWO_PI_Q;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // response side: check accepted transactions, stall in random bursts
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen.pos_x       = rsp_pos_x;
         rsp_seen.pos_y       = rsp_pos_y;
         rsp_seen.heading_out = rsp_heading_out;
         rsp_seen.vel_x       = rsp_vel_x;
         rsp_seen.vel_y       = rsp_vel_y;
         rsp_seen.yaw_rate    = rsp_yaw_rate;
         poses.check_pose(rsp_seen);
      end
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if (idle_odds != 0 && $urandom_range(1, 300) <= idle_odds) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 6);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [31:0] tv;
      logic [31:0] rv;
      int          span;
      int          step;
      int          mode;
      poses = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      idle_odds = 30;

      // first reading, then unit step straight ahead
      send_reading(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_reading(32'h0001_0000, 32'h0000_0000, 32'h0001_0000, 32'h0001_0000);
      // x saturates high, then distance counter wrap drives it low
      send_reading(32'h7FFF_FFFF, 32'h0000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      send_reading(32'h8000_0000, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001);
      // quarter turn exactly, then just past it (folded), y saturates
      send_reading(32'h7FFF_FFFF, 32'd102944, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_reading(32'h8000_0000, 32'd102945, 32'h8000_0000, 32'h8000_0000);
      // heading at pi: most negative speed overflows the velocity
      send_reading(32'h8000_0000, 32'd205887, 32'h8000_0000, 32'h0000_0000);
      // one past pi wraps to minus pi
      send_reading(32'h8001_0000, 32'd205888, 32'h0001_0000, 32'h1234_5678);
      send_reading(32'h8001_0000, 32'd205888, 32'h8000_0000, 32'hEDCB_A987);
      // minus a quarter turn exactly, then just beyond
      send_reading(32'h8002_0000, 32'd308831, 32'h0010_0000, 32'h0000_0000);
      send_reading(32'h8003_0000, 32'd308830, 32'hFFF0_0000, 32'h0000_0000);
      // bearing jumps, including the counter wrap
      send_reading(32'h8003_0000, 32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA);
      send_reading(32'h8003_0000, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555);
      send_reading(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_reading(32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
      send_reading(32'h0000_FFFF, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_0000);
      cur_dist = 32'h0000_FFFF;
      cur_bear = 32'h0000_0001;

      // random part: mostly plausible motion, some noise and corners
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 80 == 0) begin
            if (n >= RANDOM_ITEMS - 120) idle_odds = 0;
            else if ((n / 80) % 3 == 2) idle_odds = 0;
            else idle_odds = $urandom_range(15, 60);
         end
         mode = $urandom_range(0, 99);
         if (mode < 70) begin
            case ($urandom_range(0, 3))
               0:       span = 16;
               1:       span = 4096;
               2:       span = 262144;
               default: span = 8388608;
            endcase
            step     = int'($urandom_range(0, 2 * span)) - span;
            cur_dist = cur_dist + step;
            case ($urandom_range(0, 3))
               0:       span = 0;
               1:       span = 256;
               2:       span = 16384;
               default: span = 393216;
            endcase
            step     = int'($urandom_range(0, 2 * span)) - span;
            cur_bear = cur_bear + step;
            if ($urandom_range(0, 1) != 0) tv = $urandom;
            else tv = 32'(int'($urandom_range(0, 262144)) - 131072);
            rv = $urandom;
         end else if (mode < 85) begin
            cur_dist = $urandom;
            cur_bear = $urandom;
            tv       = $urandom;
            rv       = $urandom;
         end else begin
            cur_dist = corner_word();
            cur_bear = corner_word();
            tv       = corner_word();
            rv       = corner_word();
         end
         send_reading(cur_dist, cur_bear, tv, rv);
      end
      req_valid <= 1'b0;

      // drain, then let the core settle
      while (poses.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (poses.mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
